>>> rtl/core/mlg_pkg.sv
// ----------------------------------------------------------------------------
// mlg_pkg: shared types, constants and tap table for the LFSR generator
// Holds the request/response words, the cell control structs, the tap table
// and the width decode helpers.
// ----------------------------------------------------------------------------
package mlg_pkg;

   // Largest supported register width (2..64)
   localparam int MAX_WIDTH  = 64;
   localparam int VALUE_BITS = 64;
   localparam int COUNT_BITS = 32;
   localparam int WIDTH_BITS = 7;
   localparam int TAP_BITS   = 7;

   // Operation codes
   localparam logic OP_ADVANCE = 1'b0;
   localparam logic OP_LOAD    = 1'b1;

   typedef struct packed {
      logic                  op;
      logic [VALUE_BITS-1:0] new_seed;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  period_done;
      logic [COUNT_BITS-1:0] period_total;
      logic                  seed_rejected;
   } rsp_type;

   // Static per-cell decode of the configured width
   typedef struct packed {
      logic in_range;
      logic is_top;
   } cell_cfg_type;

   // Per-word command broadcast to every cell
   typedef struct packed {
      logic advance;
      logic load;
   } cell_ctl_type;

   // Tap sets, one entry per width starting at width 2; a zero tap is unused
   localparam logic [4*TAP_BITS-1:0] TAP_TABLE [0:62] = '{
      {7'd2,  7'd1,  7'd0,  7'd0},  {7'd3,  7'd2,  7'd0,  7'd0},
      {7'd4,  7'd3,  7'd0,  7'd0},
      {7'd5,  7'd4,  7'd3,  7'd2},  {7'd6,  7'd5,  7'd3,  7'd2},
      {7'd7,  7'd6,  7'd5,  7'd4},  {7'd8,  7'd6,  7'd5,  7'd4},
      {7'd9,  7'd8,  7'd6,  7'd5},  {7'd10, 7'd9,  7'd7,  7'd6},
      {7'd11, 7'd10, 7'd9,  7'd7},  {7'd12, 7'd11, 7'd8,  7'd6},
      {7'd13, 7'd12, 7'd10, 7'd9},  {7'd14, 7'd13, 7'd11, 7'd9},
      {7'd15, 7'd14, 7'd13, 7'd11}, {7'd16, 7'd14, 7'd13, 7'd11},
      {7'd17, 7'd16, 7'd15, 7'd14}, {7'd18, 7'd17, 7'd16, 7'd13},
      {7'd19, 7'd18, 7'd17, 7'd14}, {7'd20, 7'd19, 7'd16, 7'd14},
      {7'd21, 7'd20, 7'd19, 7'd16}, {7'd22, 7'd19, 7'd18, 7'd17},
      {7'd23, 7'd22, 7'd20, 7'd18}, {7'd24, 7'd23, 7'd21, 7'd20},
      {7'd25, 7'd24, 7'd23, 7'd22}, {7'd26, 7'd25, 7'd24, 7'd20},
      {7'd27, 7'd26, 7'd25, 7'd22}, {7'd28, 7'd27, 7'd24, 7'd22},
      {7'd29, 7'd28, 7'd27, 7'd25}, {7'd30, 7'd29, 7'd26, 7'd24},
      {7'd31, 7'd30, 7'd29, 7'd28}, {7'd32, 7'd30, 7'd26, 7'd25},
      {7'd33, 7'd32, 7'd29, 7'd27}, {7'd34, 7'd31, 7'd30, 7'd26},
      {7'd35, 7'd34, 7'd28, 7'd27}, {7'd36, 7'd35, 7'd29, 7'd28},
      {7'd37, 7'd36, 7'd33, 7'd31}, {7'd38, 7'd37, 7'd33, 7'd32},
      {7'd39, 7'd38, 7'd35, 7'd32}, {7'd40, 7'd37, 7'd36, 7'd35},
      {7'd41, 7'd40, 7'd39, 7'd38}, {7'd42, 7'd40, 7'd37, 7'd35},
      {7'd43, 7'd42, 7'd38, 7'd37}, {7'd44, 7'd42, 7'd39, 7'd38},
      {7'd45, 7'd44, 7'd42, 7'd41}, {7'd46, 7'd40, 7'd39, 7'd38},
      {7'd47, 7'd46, 7'd43, 7'd42}, {7'd48, 7'd44, 7'd41, 7'd39},
      {7'd49, 7'd45, 7'd44, 7'd43}, {7'd50, 7'd48, 7'd47, 7'd46},
      {7'd51, 7'd50, 7'd48, 7'd45}, {7'd52, 7'd51, 7'd49, 7'd46},
      {7'd53, 7'd52, 7'd51, 7'd47}, {7'd54, 7'd51, 7'd48, 7'd46},
      {7'd55, 7'd54, 7'd53, 7'd49}, {7'd56, 7'd54, 7'd52, 7'd49},
      {7'd57, 7'd55, 7'd54, 7'd52}, {7'd58, 7'd57, 7'd53, 7'd52},
      {7'd59, 7'd57, 7'd55, 7'd52}, {7'd60, 7'd58, 7'd56, 7'd55},
      {7'd61, 7'd60, 7'd59, 7'd56}, {7'd62, 7'd59, 7'd57, 7'd56},
      {7'd63, 7'd62, 7'd59, 7'd58}, {7'd64, 7'd63, 7'd61, 7'd60}
   };

   // Clamp a written width into 2..MAX_WIDTH
   function automatic logic [WIDTH_BITS-1:0] clamp_width(input logic [WIDTH_BITS-1:0] width);
      logic [WIDTH_BITS-1:0] result;
      result = width;
      if (width < WIDTH_BITS'(2)) result = WIDTH_BITS'(2);
      if (width > WIDTH_BITS'(MAX_WIDTH)) result = WIDTH_BITS'(MAX_WIDTH);
      return result;
   endfunction

   // Register bits read by the taps of a clamped width: tap t reads bit w - t
   function automatic logic [VALUE_BITS-1:0] tap_mask(input logic [WIDTH_BITS-1:0] width);
      logic [WIDTH_BITS-1:0] index;
      logic [4*TAP_BITS-1:0] entry;
      logic [TAP_BITS-1:0]   tap;
      logic [WIDTH_BITS-1:0] pos;
      logic [VALUE_BITS-1:0] mask;
      index = width - WIDTH_BITS'(2);
      entry = TAP_TABLE[index[5:0]];
      mask  = '0;
      for (int k = 0; k < 4; k++) begin
         tap = entry[k*TAP_BITS +: TAP_BITS];
         pos = width - tap;
         if (tap != '0) mask[pos[5:0]] = 1'b1;
      end
      return mask;
   endfunction

   // Bits below the clamped width
   function automatic logic [VALUE_BITS-1:0] width_mask(input logic [WIDTH_BITS-1:0] width);
      logic [VALUE_BITS-1:0] mask;
      for (int i = 0; i < VALUE_BITS; i++) begin
         mask[i] = (WIDTH_BITS'(i) < width);
      end
      return mask;
   endfunction

   // Top bit of the clamped width, which takes the feedback
   function automatic logic [VALUE_BITS-1:0] top_mask(input logic [WIDTH_BITS-1:0] width);
      logic [WIDTH_BITS-1:0] pos;
      logic [VALUE_BITS-1:0] mask;
      pos  = width - WIDTH_BITS'(1);
      mask = '0;
      mask[pos[5:0]] = 1'b1;
      return mask;
   endfunction

endpackage

>>> rtl/core/mlg_cell.sv
// ----------------------------------------------------------------------------
// mlg_cell: one bit of the shift register
// Holds one bit of the running value and one bit of the start value, takes
// its neighbor's bit on an advance and flags whether the advanced bit matches
// the start bit.
// ----------------------------------------------------------------------------
module mlg_cell
   import mlg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         reset_bit,
   input  cell_cfg_type cfg,
   input  cell_ctl_type ctl,
   input  logic         seed_bit,
   input  logic         upper_bit,
   input  logic         feedback,
   output logic         shift_bit,
   output logic         next_bit,
   output logic         match
);

   logic shift_ff, shift_in;
   logic start_ff, start_in;
   logic adv_bit;
   logic load_bit;

   // Shift from the upper neighbor, top cell takes the feedback, drop bits above width
   assign adv_bit  = cfg.is_top ? feedback : (cfg.in_range & upper_bit);
   assign load_bit = seed_bit & cfg.in_range;

   always_comb begin
      shift_in = shift_ff;
      if (ctl.load) begin
         shift_in = load_bit;
      end else if (ctl.advance) begin
         shift_in = adv_bit;
      end
   end

   assign start_in = ctl.load ? load_bit : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= reset_bit;
         start_ff <= reset_bit;
      end else begin
         shift_ff <= shift_in;
         start_ff <= start_in;
      end
   end

   assign shift_bit = shift_ff;
   assign next_bit  = shift_in;
   assign match     = (adv_bit == (start_ff & cfg.in_range));

endmodule

>>> rtl/core/mlg_out_buffer.sv
// ----------------------------------------------------------------------------
// mlg_out_buffer: response register with skid stage
// Registers each response word and parks one more word while the consumer
// stalls, so the request side stalls only from a registered flag.
// ----------------------------------------------------------------------------
module mlg_out_buffer
   import mlg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    word_valid,
   input  rsp_type word_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   // Refill the output from the skid first, else from the new word
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = word_valid;
            out_data_in   = word_data;
         end
      end else if (word_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = word_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

>>> rtl/core/max_length_lfsr_generator.sv
// ----------------------------------------------------------------------------
// max_length_lfsr_generator: maximal-length Fibonacci LFSR, 2 to 64 bits
// Row of bit cells with a shared tap parity, period counter and response
// buffer.
// ----------------------------------------------------------------------------
// The generator takes one request word per clock while req_stall is low and
// returns one response word for each from the response register. An advance word
// shifts the register right one bit with the tap parity entering the top bit
// of the configured width; a load word sets a new start value (masked to the
// width) unless it masks to zero, in which case it is rejected and nothing
// changes. Each advance that lands on the start value bumps a saturating
// 32-bit period count. The whole step is one pass through the row of 64 bit
// cells plus a 64-bit match reduction and a 32-bit increment, which sets the
// rate of one word per cycle. A skid stage absorbs one word when the consumer
// stalls, so req_stall rises only once that stage is occupied. The width
// register is decoded into tap, width and top-bit masks when written; write
// it only while no word is in flight. Widths below 2 act as 2.
// ----------------------------------------------------------------------------
module max_length_lfsr_generator
   import mlg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [WIDTH_BITS-1:0] csr_data
);

   logic [VALUE_BITS-1:0] tap_mask_ff, tap_mask_in;
   logic [VALUE_BITS-1:0] width_mask_ff, width_mask_in;
   logic [VALUE_BITS-1:0] top_mask_ff, top_mask_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [WIDTH_BITS-1:0] width_clamped;

   logic                  accept;
   logic                  seed_nonzero;
   logic                  feedback;
   logic                  period_done;
   cell_ctl_type          ctl;
   logic [VALUE_BITS-1:0] shift_vec;
   logic [VALUE_BITS-1:0] next_vec;
   logic [VALUE_BITS-1:0] match_vec;
   rsp_type               word;
   logic                  buffer_full;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign req_stall = buffer_full;

   // Decode the width once per write
   assign width_clamped = clamp_width(csr_data);
   assign tap_mask_in   = (csr_valid && csr_ready) ? tap_mask(width_clamped) : tap_mask_ff;
   assign width_mask_in = (csr_valid && csr_ready) ? width_mask(width_clamped) : width_mask_ff;
   assign top_mask_in   = (csr_valid && csr_ready) ? top_mask(width_clamped) : top_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_mask_ff   <= tap_mask(WIDTH_BITS'(MAX_WIDTH));
         width_mask_ff <= width_mask(WIDTH_BITS'(MAX_WIDTH));
         top_mask_ff   <= top_mask(WIDTH_BITS'(MAX_WIDTH));
      end else begin
         tap_mask_ff   <= tap_mask_in;
         width_mask_ff <= width_mask_in;
         top_mask_ff   <= top_mask_in;
      end
   end

   // Command to the cells: reject a seed that masks to zero
   assign seed_nonzero = |(req_data.new_seed & width_mask_ff);
   assign ctl.advance  = accept && (req_data.op == OP_ADVANCE);
   assign ctl.load     = accept && (req_data.op == OP_LOAD) && seed_nonzero;

   // Tap parity over the current register
   assign feedback = ^(shift_vec & tap_mask_ff);

   // Row of bit cells, each taking its upper neighbor's bit
   for (genvar i = 0; i < VALUE_BITS; i++) begin : g_cell
      cell_cfg_type cfg;
      logic         upper;
      assign cfg.in_range = width_mask_ff[i];
      assign cfg.is_top   = top_mask_ff[i];
      if (i == VALUE_BITS - 1) begin : g_top
         assign upper = 1'b0;
      end else begin : g_mid
         assign upper = shift_vec[i+1];
      end
      mlg_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .reset_bit (i == 0),
         .cfg       (cfg),
         .ctl       (ctl),
         .seed_bit  (req_data.new_seed[i]),
         .upper_bit (upper),
         .feedback  (feedback),
         .shift_bit (shift_vec[i]),
         .next_bit  (next_vec[i]),
         .match     (match_vec[i])
      );
   end

   // Count completed periods, hold at all ones
   assign period_done = ctl.advance && (&match_vec);
   assign count_in    = (period_done && (count_ff != '1)) ? count_ff + COUNT_BITS'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Assemble the response word
   always_comb begin
      word.value         = next_vec;
      word.period_done   = period_done;
      word.period_total  = count_in;
      word.seed_rejected = accept && (req_data.op == OP_LOAD) && !seed_nonzero;
   end

   mlg_out_buffer u_out_buffer (
      .clock      (clock),
      .reset      (reset),
      .word_valid (accept),
      .word_data  (word),
      .full       (buffer_full),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

>>> rtl/core/mlg_checker.sv
// ----------------------------------------------------------------------------
// mlg_checker: port-level checks for the LFSR generator
// Watches the top-level ports and flags response ordering and flag slips.
// ----------------------------------------------------------------------------
module mlg_checker
   import mlg_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // Hold a stalled response word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed");

   // Return a word the cycle after an accept into an empty buffer
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && !req_stall |=> rsp_valid)
      else $error("accepted word produced no response");

   // Never flag a period and a rejected seed together; a period needs a nonzero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.period_done |-> !rsp_data.seed_rejected &&
      (rsp_data.period_total != '0))
      else $error("inconsistent period or reject flags");

   // Keep the period count from going backward between words
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall ##1 rsp_valid |->
      rsp_data.period_total >= $past(rsp_data.period_total))
      else $error("period count decreased");

endmodule

bind max_length_lfsr_generator mlg_checker u_mlg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
